@@ hdl/lcar_pkg.sv @@
package lcar_pkg;

  // Default converter word length in bits.
  localparam int SAMPLE_BITS_DEFAULT = 24;

  // Width of the offset and the reported weight.
  localparam int WEIGHT_W = 32;

  // Width of the configuration registers and their counters.
  localparam int CFG_W = 16;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] TARE_COUNT_RESET = 16'd16;
  localparam logic [CFG_W-1:0] TIMEOUT_RESET    = 16'd60000;

  // Operation codes carried on the input channel.
  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_READ       = 3'd1;
  localparam logic [2:0] OP_TARE       = 3'd2;
  localparam logic [2:0] OP_ADJUST     = 3'd3;
  localparam logic [2:0] OP_POWER_DOWN = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_TARE_COUNT = 1'b0;
  localparam logic CFG_TIMEOUT    = 1'b1;

  // Phases of one conversion sequence.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WAIT  = 2'd1,
    PH_SHIFT = 2'd2,
    PH_GAIN  = 2'd3
  } phase_t;

endpackage

@@ hdl/load_cell_adc_reader_with_tare.sv @@
// Load-cell converter reader with tare, for a two-wire serial converter.
// Each input beat is one half-period tick of the serial clock. The beat
// carries an operation code, the sampled level of the converter's data pin
// and a signed offset adjustment; each beat yields exactly one result beat
// with the clock level to drive for that tick, busy and done flags, a
// timeout status and the net weight (sample minus zero offset).
// A read waits for the data pin to fall, clocks SAMPLE_BITS bits MSB first
// and one gain pulse, then reports the weight. A tare runs the configured
// number of conversions (at least one) and sets the offset to the middle
// of their range. The configuration channel writes the tare count
// (index 0) and the ready timeout (index 1); it is always ready and takes
// effect at once. The result of a beat is registered at the edge that
// accepts it. Throughput is one beat per cycle, set by the single output
// register, which accepts a new beat whenever it is empty or being drained.
// When the receiver stalls, the result holds and input ready drops until the
// result is taken. Synchronous reset clears the sequence to idle, the offset
// to zero, the converter to powered up and the registers to 16 and 60000.
module load_cell_adc_reader_with_tare #(
  parameter int SAMPLE_BITS = lcar_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         operation,
  input  logic                               dout_level,
  input  logic signed [lcar_pkg::WEIGHT_W-1:0] offset_adjust,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               sck_level,
  output logic                               busy_res,
  output logic                               done_res,
  output logic                               status,
  output logic signed [lcar_pkg::WEIGHT_W-1:0] net_weight,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [lcar_pkg::CFG_W-1:0]         cfg_data
);

  localparam int WW    = lcar_pkg::WEIGHT_W;
  localparam int CW    = lcar_pkg::CFG_W;
  localparam int BIT_W = $clog2(SAMPLE_BITS + 1);

  // Configuration registers.
  logic [CW-1:0] tare_sample_count;
  logic [CW-1:0] ready_timeout_ticks;

  // Sequence state.
  lcar_pkg::phase_t          phase, phase_next;
  logic                      tare_mode, tare_mode_next;
  logic [BIT_W-1:0]          bit_counter, bit_counter_next;
  logic                      clock_half, clock_half_next;
  logic [CW-1:0]             wait_counter, wait_counter_next;
  logic [CW-1:0]             samples_taken, samples_taken_next;
  logic [SAMPLE_BITS-1:0]    shift_register, shift_register_next;
  logic signed [SAMPLE_BITS-1:0] running_min, running_min_next;
  logic signed [SAMPLE_BITS-1:0] running_max, running_max_next;
  logic [WW-1:0]             zero_offset, zero_offset_next;
  logic                      powered_down, powered_down_next;

  // Result of the current beat.
  logic          sck_c, busy_c, done_c, status_c;
  logic [WW-1:0] net_c;

  // Shared datapath terms.
  logic                      in_fire;
  logic                      is_start;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [WW-1:0]             sample_ext;
  logic [BIT_W-1:0]          bit_counter_inc;
  logic [CW-1:0]             samples_inc;
  logic [CW-1:0]             samples_need;
  logic signed [SAMPLE_BITS-1:0] min_upd, max_upd;
  logic [SAMPLE_BITS:0]      span;
  logic [WW-1:0]             tare_offset;

  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign is_start = (operation == lcar_pkg::OP_READ) || (operation == lcar_pkg::OP_TARE);

  // Sign-extended sample and the tare range update.
  assign sample          = $signed(shift_register);
  assign sample_ext      = {{(WW-SAMPLE_BITS){shift_register[SAMPLE_BITS-1]}}, shift_register};
  assign bit_counter_inc = bit_counter + BIT_W'(1);
  assign samples_inc     = samples_taken + CW'(1);
  assign samples_need    = (tare_sample_count == '0) ? CW'(1) : tare_sample_count;
  assign min_upd = ((samples_taken == '0) || (sample < running_min)) ? sample : running_min;
  assign max_upd = ((samples_taken == '0) || (sample > running_max)) ? sample : running_max;
  assign span    = {max_upd[SAMPLE_BITS-1], max_upd} - {min_upd[SAMPLE_BITS-1], min_upd};
  assign tare_offset = {{(WW-SAMPLE_BITS){min_upd[SAMPLE_BITS-1]}}, min_upd}
                     + {{(WW-SAMPLE_BITS){1'b0}}, span[SAMPLE_BITS:1]};

  // Next state of the sequence.
  always_comb begin
    phase_next          = phase;
    tare_mode_next      = tare_mode;
    bit_counter_next    = bit_counter;
    clock_half_next     = clock_half;
    wait_counter_next   = wait_counter;
    samples_taken_next  = samples_taken;
    shift_register_next = shift_register;
    running_min_next    = running_min;
    running_max_next    = running_max;
    zero_offset_next    = zero_offset;
    powered_down_next   = powered_down;
    unique case (phase)
      lcar_pkg::PH_IDLE: begin
        if (is_start) begin
          powered_down_next  = 1'b0;
          phase_next         = lcar_pkg::PH_WAIT;
          tare_mode_next     = (operation == lcar_pkg::OP_TARE);
          wait_counter_next  = '0;
          bit_counter_next   = '0;
          clock_half_next    = 1'b0;
          samples_taken_next = '0;
        end else if (operation == lcar_pkg::OP_ADJUST) begin
          zero_offset_next = zero_offset + offset_adjust;
        end else if (operation == lcar_pkg::OP_POWER_DOWN) begin
          powered_down_next = 1'b1;
        end
      end
      lcar_pkg::PH_WAIT: begin
        if (!dout_level) begin
          phase_next          = lcar_pkg::PH_SHIFT;
          bit_counter_next    = '0;
          clock_half_next     = 1'b0;
          shift_register_next = '0;
        end else if (wait_counter >= ready_timeout_ticks) begin
          phase_next = lcar_pkg::PH_IDLE;
        end else begin
          wait_counter_next = wait_counter + CW'(1);
        end
      end
      lcar_pkg::PH_SHIFT: begin
        clock_half_next = !clock_half;
        if (clock_half) begin
          shift_register_next = {shift_register[SAMPLE_BITS-2:0], dout_level};
          bit_counter_next    = bit_counter_inc;
          if (bit_counter_inc >= BIT_W'(SAMPLE_BITS)) begin
            phase_next = lcar_pkg::PH_GAIN;
          end
        end
      end
      lcar_pkg::PH_GAIN: begin
        clock_half_next = !clock_half;
        if (clock_half) begin
          if (!tare_mode) begin
            phase_next = lcar_pkg::PH_IDLE;
          end else begin
            running_min_next   = min_upd;
            running_max_next   = max_upd;
            samples_taken_next = samples_inc;
            if (samples_inc >= samples_need) begin
              zero_offset_next = tare_offset;
              phase_next       = lcar_pkg::PH_IDLE;
            end else begin
              phase_next        = lcar_pkg::PH_WAIT;
              wait_counter_next = '0;
            end
          end
        end
      end
      default: begin
        phase_next = lcar_pkg::PH_IDLE;
      end
    endcase
  end

  // Result fields of the current tick.
  always_comb begin
    sck_c    = 1'b0;
    busy_c   = 1'b0;
    done_c   = 1'b0;
    status_c = 1'b0;
    net_c    = '0;
    unique case (phase)
      lcar_pkg::PH_IDLE: begin
        if (is_start) begin
          busy_c = 1'b1;
        end else begin
          sck_c = powered_down || (operation == lcar_pkg::OP_POWER_DOWN);
        end
      end
      lcar_pkg::PH_WAIT: begin
        if (dout_level && (wait_counter >= ready_timeout_ticks)) begin
          done_c   = 1'b1;
          status_c = 1'b1;
        end else begin
          busy_c = 1'b1;
        end
      end
      lcar_pkg::PH_SHIFT: begin
        busy_c = 1'b1;
        sck_c  = !clock_half;
      end
      lcar_pkg::PH_GAIN: begin
        sck_c  = !clock_half;
        busy_c = 1'b1;
        if (clock_half) begin
          if (!tare_mode) begin
            net_c  = sample_ext - zero_offset;
            busy_c = 1'b0;
            done_c = 1'b1;
          end else if (samples_inc >= samples_need) begin
            busy_c = 1'b0;
            done_c = 1'b1;
          end
        end
      end
      default: begin
        busy_c = 1'b0;
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      tare_sample_count   <= lcar_pkg::TARE_COUNT_RESET;
      ready_timeout_ticks <= lcar_pkg::TIMEOUT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lcar_pkg::CFG_TARE_COUNT: tare_sample_count   <= cfg_data;
        lcar_pkg::CFG_TIMEOUT:    ready_timeout_ticks <= cfg_data;
        default:                  tare_sample_count   <= tare_sample_count;
      endcase
    end
  end

  // Sequence state advances once per accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= lcar_pkg::PH_IDLE;
      tare_mode      <= 1'b0;
      bit_counter    <= '0;
      clock_half     <= 1'b0;
      wait_counter   <= '0;
      samples_taken  <= '0;
      shift_register <= '0;
      running_min    <= '0;
      running_max    <= '0;
      zero_offset    <= '0;
      powered_down   <= 1'b0;
    end else if (in_fire) begin
      phase          <= phase_next;
      tare_mode      <= tare_mode_next;
      bit_counter    <= bit_counter_next;
      clock_half     <= clock_half_next;
      wait_counter   <= wait_counter_next;
      samples_taken  <= samples_taken_next;
      shift_register <= shift_register_next;
      running_min    <= running_min_next;
      running_max    <= running_max_next;
      zero_offset    <= zero_offset_next;
      powered_down   <= powered_down_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_fire || (out_valid && !out_ready);
    end
  end

  // Output payload, loaded with each accepted beat.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sck_level  <= sck_c;
      busy_res   <= busy_c;
      done_res   <= done_c;
      status     <= status_c;
      net_weight <= net_c;
    end
  end

endmodule

@@ hdl/lcar_checker.sv @@
module lcar_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             busy_res,
  input logic                             done_res,
  input logic                             status,
  input logic [lcar_pkg::WEIGHT_W-1:0]    net_weight
);

  // Every accepted beat produces a result beat in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted beat produced no result");

  // A stalled result beat holds its payload.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(done_res) && $stable(net_weight)))
    else $error("stalled result changed");

  // A finishing tick is never a busy tick.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> !busy_res)
    else $error("done and busy together");

  // Timeout status only appears on a finishing tick without a weight.
  a_status_with_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (done_res && (net_weight == '0)))
    else $error("status outside a done beat");

  // A nonzero weight comes only with a successful finish.
  a_weight_with_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (net_weight != '0)) |-> (done_res && !status && !busy_res))
    else $error("weight outside a successful done beat");

endmodule

bind load_cell_adc_reader_with_tare lcar_checker u_lcar_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .busy_res   (busy_res),
  .done_res   (done_res),
  .status     (status),
  .net_weight (net_weight)
);

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lcar_pkg::*;

  localparam int SBITS = SAMPLE_BITS_DEFAULT;

  // One result beat as the block reports it.
  typedef struct packed {
    logic                sck;
    logic                busy;
    logic                done;
    logic                status;
    logic [WEIGHT_W-1:0] net;
  } weight_beat_t;

  // Tracks the converter reader: predicts one result beat per tick beat and
  // compares what the block reports against the oldest prediction.
  class weight_scoreboard;
    // Configuration registers.
    logic [CFG_W-1:0] tare_count;
    logic [CFG_W-1:0] timeout_ticks;

    // Sequence state.
    phase_t                     phase;
    bit                         tare_run;
    logic [4:0]                 bits_done;
    bit                         half;
    logic [CFG_W-1:0]           wait_cnt;
    logic [CFG_W-1:0]           taken;
    logic [SBITS-1:0]           shreg;
    logic signed [WEIGHT_W-1:0] lo;
    logic signed [WEIGHT_W-1:0] hi;
    logic [WEIGHT_W-1:0]        offset;
    bit                         asleep;

    weight_beat_t expq[$];
    int mismatches;
    int beats_checked;
    int reads_ok;
    int tares_done;
    int timeouts;

    function new();
      tare_count    = TARE_COUNT_RESET;
      timeout_ticks = TIMEOUT_RESET;
      phase         = PH_IDLE;
      tare_run      = 1'b0;
      bits_done     = '0;
      half          = 1'b0;
      wait_cnt      = '0;
      taken         = '0;
      shreg         = '0;
      lo            = '0;
      hi            = '0;
      offset        = '0;
      asleep        = 1'b0;
      mismatches    = 0;
      beats_checked = 0;
      reads_ok      = 0;
      tares_done    = 0;
      timeouts      = 0;
    endfunction

    function void set_reg(logic idx, logic [CFG_W-1:0] val);
      if (idx == CFG_TARE_COUNT) begin
        tare_count = val;
      end else begin
        timeout_ticks = val;
      end
    endfunction

    function int pending();
      return expq.size();
    endfunction

    // Advances the sequence by one tick and queues the expected result.
    function void note_input(logic [2:0] op, logic dout, logic [WEIGHT_W-1:0] adj);
      weight_beat_t               r;
      logic signed [WEIGHT_W-1:0] sample;
      logic [WEIGHT_W-1:0]        span;
      logic [CFG_W-1:0]           need;
      r = '0;
      case (phase)
        PH_IDLE: begin
          if (op == OP_READ || op == OP_TARE) begin
            // A start wakes the converter and opens a new sequence.
            asleep    = 1'b0;
            tare_run  = (op == OP_TARE);
            phase     = PH_WAIT;
            wait_cnt  = '0;
            bits_done = '0;
            half      = 1'b0;
            taken     = '0;
            r.busy    = 1'b1;
          end else begin
            if (op == OP_ADJUST) begin
              offset = offset + adj;
            end else if (op == OP_POWER_DOWN) begin
              asleep = 1'b1;
            end
            r.sck = asleep;
          end
        end
        PH_WAIT: begin
          // The clock stays low until the data line falls or time runs out.
          r.busy = 1'b1;
          if (!dout) begin
            phase     = PH_SHIFT;
            bits_done = '0;
            half      = 1'b0;
            shreg     = '0;
          end else if (wait_cnt >= timeout_ticks) begin
            phase    = PH_IDLE;
            r.busy   = 1'b0;
            r.done   = 1'b1;
            r.status = 1'b1;
            timeouts++;
          end else begin
            wait_cnt = wait_cnt + 1'b1;
          end
        end
        PH_SHIFT: begin
          // High tick, then a low tick that samples the next bit.
          r.busy = 1'b1;
          if (!half) begin
            r.sck = 1'b1;
            half  = 1'b1;
          end else begin
            half      = 1'b0;
            shreg     = {shreg[SBITS-2:0], dout};
            bits_done = bits_done + 1'b1;
            if (bits_done >= SBITS) begin
              phase = PH_GAIN;
            end
          end
        end
        default: begin
          // Gain pulse; the sample is complete on its low tick.
          r.busy = 1'b1;
          if (!half) begin
            r.sck = 1'b1;
            half  = 1'b1;
          end else begin
            half   = 1'b0;
            sample = {{(WEIGHT_W-SBITS){shreg[SBITS-1]}}, shreg};
            if (!tare_run) begin
              r.net  = sample - offset;
              r.busy = 1'b0;
              r.done = 1'b1;
              phase  = PH_IDLE;
              reads_ok++;
            end else begin
              need = (tare_count == '0) ? CFG_W'(1) : tare_count;
              if (taken == 0) begin
                lo = sample;
                hi = sample;
              end else begin
                if (sample > hi) hi = sample;
                if (sample < lo) lo = sample;
              end
              taken = taken + 1'b1;
              if (taken >= need) begin
                span   = hi - lo;
                offset = lo + (span >> 1);
                r.busy = 1'b0;
                r.done = 1'b1;
                phase  = PH_IDLE;
                tares_done++;
              end else begin
                phase    = PH_WAIT;
                wait_cnt = '0;
              end
            end
          end
        end
      endcase
      expq.push_back(r);
    endfunction

    function void flag(string what, logic [WEIGHT_W-1:0] want, logic [WEIGHT_W-1:0] got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
      end
    endfunction

    function void check_result(weight_beat_t got);
      weight_beat_t want;
      if (expq.size() == 0) begin
        flag("result beat with nothing expected, net_weight", '0, got.net);
        return;
      end
      want = expq.pop_front();
      beats_checked++;
      if (got.sck !== want.sck) flag("sck_level", want.sck, got.sck);
      if (got.busy !== want.busy) flag("busy_res", want.busy, got.busy);
      if (got.done !== want.done) flag("done_res", want.done, got.done);
      if (got.status !== want.status) flag("status", want.status, got.status);
      if (got.net !== want.net) flag("net_weight", want.net, got.net);
    endfunction
  endclass

  logic                clk;
  logic                rst           = 1'b1;
  logic                in_valid      = 1'b0;
  logic                in_ready;
  logic [2:0]          operation     = OP_TICK;
  logic                dout_level    = 1'b1;
  logic [WEIGHT_W-1:0] offset_adjust = '0;
  logic                out_valid;
  logic                out_ready     = 1'b0;
  logic                sck_level;
  logic                busy_res;
  logic                done_res;
  logic                status;
  logic [WEIGHT_W-1:0] net_weight;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic                cfg_index     = CFG_TARE_COUNT;
  logic [CFG_W-1:0]    cfg_data      = '0;

  weight_scoreboard board;
  bit               gaps_on = 1'b1;
  int unsigned      stall_left = 0;
  // Word the converter presents during the current conversion.
  logic [SBITS-1:0] conv_word = {1'b1, {(SBITS-1){1'b0}}};

  load_cell_adc_reader_with_tare DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .dout_level    (dout_level),
    .offset_adjust (offset_adjust),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sck_level     (sck_level),
    .busy_res      (busy_res),
    .done_res      (done_res),
    .status        (status),
    .net_weight    (net_weight),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: take a beat, then hold ready low for a random stall when gaps are on.
  always @(posedge clk) begin : result_sink
    weight_beat_t seen;
    int unsigned  hold;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_ready) begin
      if (out_valid) begin
        seen.sck    = sck_level;
        seen.busy   = busy_res;
        seen.done   = done_res;
        seen.status = status;
        seen.net    = net_weight;
        board.check_result(seen);
        hold = gaps_on ? $urandom_range(0, 12) : 0;
        if (hold != 0) begin
          out_ready  <= 1'b0;
          stall_left <= hold;
        end
      end
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Sends one tick beat after an optional gap; valid stays up afterwards.
  task automatic send_item(logic [2:0] op, logic dout, logic [WEIGHT_W-1:0] adj);
    int gap;
    gap = gaps_on ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    dout_level    <= dout;
    offset_adjust <= adj;
    do @(posedge clk); while (!in_ready);
    board.note_input(op, dout, adj);
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
  endtask

  task automatic set_config(logic [CFG_W-1:0] count, logic [CFG_W-1:0] limit);
    write_reg(CFG_TARE_COUNT, count);
    write_reg(CFG_TIMEOUT, limit);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic that plays the converter: the data line falls after a
  // random wait and then presents a chosen word MSB first on the low ticks.
  task automatic run_phase(int n, int high_pct, bit pause_mid);
    int                  sent;
    int                  roll;
    logic [2:0]          op;
    logic                dout;
    logic [WEIGHT_W-1:0] adj;
    sent = 0;
    while (sent < n || board.phase != PH_IDLE) begin
      dout = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: adj = 32'h8000_0000;
          1: adj = 32'h7FFF_FFFF;
          2: adj = 32'hFFFF_FFFF;
          default: adj = '0;
        endcase
      end else begin
        adj = $urandom();
      end
      if (board.phase == PH_IDLE) begin
        roll = $urandom_range(0, 99);
        if (roll < 35) op = OP_READ;
        else if (roll < 50) op = OP_TARE;
        else if (roll < 65) op = OP_ADJUST;
        else if (roll < 72) op = OP_POWER_DOWN;
        else if (roll < 85) op = OP_TICK;
        else op = 3'($urandom_range(5, 7));
      end else begin
        // Operations during a sequence should be ignored.
        op = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : OP_TICK;
        case (board.phase)
          PH_WAIT: begin
            dout = ($urandom_range(0, 99) < high_pct);
            if (!dout) begin
              case ($urandom_range(0, 7))
                0: conv_word = {1'b0, {(SBITS-1){1'b1}}};
                1: conv_word = {1'b1, {(SBITS-1){1'b0}}};
                2: conv_word = '0;
                3: conv_word = '1;
                default: conv_word = SBITS'($urandom());
              endcase
            end
          end
          PH_SHIFT: begin
            if (board.half) dout = conv_word[SBITS-1-board.bits_done];
          end
          default: ;
        endcase
      end
      send_item(op, dout, adj);
      sent++;
      if (pause_mid && sent == n / 2) drain_results();
    end
  endtask

  initial begin
    board = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed beats: offset extremes, power down, unused codes, a wake-up
    // read and operations that arrive while the read is busy.
    send_item(OP_TICK, 1'b0, '0);
    send_item(OP_ADJUST, 1'b1, 32'h7FFF_FFFF);
    send_item(OP_ADJUST, 1'b0, 32'h8000_0000);
    send_item(OP_ADJUST, 1'b1, 32'hFFFF_FFFF);
    send_item(OP_POWER_DOWN, 1'b0, '0);
    send_item(OP_ADJUST, 1'b1, 32'h0000_0001);
    send_item(3'd5, 1'b1, 32'hFFFF_FFFF);
    send_item(3'd6, 1'b0, 32'h5555_5555);
    send_item(3'd7, 1'b1, 32'hAAAA_AAAA);
    send_item(OP_TICK, 1'b1, '0);
    send_item(OP_READ, 1'b1, '0);
    send_item(OP_TARE, 1'b1, '0);
    send_item(OP_POWER_DOWN, 1'b1, '0);
    send_item(OP_ADJUST, 1'b0, 32'h1234_5678);
    run_phase(60, 50, 1'b0);

    // Zero tare count and zero timeout, with no idling on either side.
    drain_results();
    set_config('0, '0);
    gaps_on = 1'b0;
    run_phase(200, 30, 1'b0);

    // Long timeout, short tares; the sender pauses halfway for a full drain.
    drain_results();
    set_config(16'd3, 16'hFFFF);
    gaps_on = 1'b1;
    run_phase(300, 60, 1'b1);

    // Largest tare count with a tight timeout, so tares end on a timeout.
    drain_results();
    set_config(16'hFFFF, 16'd1);
    run_phase(150, 85, 1'b0);

    drain_results();
    set_config(16'd1, 16'd4);
    gaps_on = 1'b0;
    run_phase(250, 50, 1'b0);

    drain_results();
    set_config(16'd2, 16'd2);
    gaps_on = 1'b1;
    run_phase(250, 40, 1'b0);

    drain_results();
    repeat (4) @(posedge clk);
    if (board.pending() != 0) begin
      $display("%0d expected result beats never arrived", board.pending());
    end
    $display("Checked %0d result beats with %0d mismatches.",
             board.beats_checked, board.mismatches);
    $display("Sequences seen: %0d weight reads, %0d tares, %0d ready timeouts.",
             board.reads_ok, board.tares_done, board.timeouts);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog for a block that stops answering.
  initial begin
    #4ms;
    $display("tb_top failed");
    $finish;
  end

endmodule

@@ files.f @@
hdl/lcar_pkg.sv
hdl/load_cell_adc_reader_with_tare.sv
hdl/lcar_checker.sv
tb/tb_top.sv
